### rtl/hte_pkg.sv
package hte_pkg;

  // default sizing of the bin store
  localparam int BINS_DEF       = 256;
  localparam int COUNT_BITS_DEF = 32;

  // register and field widths
  localparam int VALUE_W = 32;
  localparam int MAXV_W  = 9;
  localparam int OUT_W   = 32;
  // a binned value never exceeds the effective maximum, which fits the register width
  localparam int BIDX_W  = MAXV_W;

  localparam logic [MAXV_W-1:0] MAXV_RESET = 9'd256;

  // queue between the front and back parts
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = QPTR_W + 1;

  // one classified item
  typedef struct packed {
    logic              hit;
    logic [BIDX_W-1:0] idx;
    logic              last;
    logic [MAXV_W-1:0] max_eff;
  } item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/hte_front.sv
module hte_front
  import hte_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [MAXV_W-1:0]         cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  input  q_stat_t                   q_stat,
  output logic                      q_push,
  output item_t                     q_item
);

  logic [MAXV_W-1:0]  max_value_r;
  logic [MAXV_W-1:0]  max_eff;
  logic [VALUE_W-1:0] raw;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= MAXV_RESET;
    end else if (cfg_wr_en) begin
      max_value_r <= cfg_wr_data;
    end
  end

  // effective maximum: zero reads as one, clamp to the bin count
  always_comb begin
    max_eff = max_value_r;
    if (max_eff == '0) begin
      max_eff = MAXV_W'(1);
    end
    if (32'(max_eff) > BINS) begin
      max_eff = MAXV_W'(BINS);
    end
  end

  // classify the incoming number
  assign raw = $unsigned(in_value);

  always_comb begin
    q_item.hit     = !raw[VALUE_W-1] && (raw != '0) && (raw <= VALUE_W'(max_eff));
    q_item.idx     = raw[BIDX_W-1:0] - BIDX_W'(1);
    q_item.last    = in_last;
    q_item.max_eff = max_eff;
  end

  // accept while the queue has room
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

endmodule

### rtl/hte_queue.sv
module hte_queue
  import hte_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t stat
);

  item_t                slots_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r;
  logic [QPTR_W-1:0]    rd_ptr_r;
  logic [QCOUNT_W-1:0]  count_r;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (count_r == QCOUNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCOUNT_W'(1);
      end
    end
  end

  // storage slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/hte_back.sv
module hte_back
  import hte_pkg::*;
#(
  parameter int BINS       = BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  item_t             q_head,
  input  q_stat_t           q_stat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_numbers_seen,
  output logic [OUT_W-1:0]  out_in_range_total,
  output logic [MAXV_W-1:0] out_most_frequent,
  output logic [MAXV_W-1:0] out_least_frequent
);

  localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CMP_W = (IDX_W > MAXV_W) ? IDX_W : MAXV_W;
  localparam int EXT_W = CMP_W + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  localparam logic [IDX_W-1:0]      IDX_END   = IDX_W'(BINS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  logic [1:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      sc_idx_r;

  // bin memory and its ports
  logic [COUNT_BITS-1:0] mem [BINS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  // last write, for forwarding
  logic                  lw_vld_r;
  logic [IDX_W-1:0]      lw_addr_r;
  logic [COUNT_BITS-1:0] lw_data_r;

  // update stage
  logic                  b_vld_r;
  logic                  b_hit_r;
  logic                  b_last_r;
  logic [IDX_W-1:0]      b_idx_r;
  logic [MAXV_W-1:0]     b_max_r;
  logic [COUNT_BITS-1:0] b_cur;
  logic [COUNT_BITS-1:0] b_inc;

  // set counters and report
  logic [COUNT_BITS-1:0] seen_r;
  logic [COUNT_BITS-1:0] seen_inc;
  logic [OUT_W-1:0]      seen_clip;
  logic [OUT_W-1:0]      seen_rep_r;
  logic [MAXV_W-1:0]     max_rep_r;

  // scan stage
  logic                  s_vld_r;
  logic [IDX_W-1:0]      s_idx_r;
  logic [COUNT_BITS-1:0] tot_r;
  logic [COUNT_BITS:0]   tot_sum;
  logic [COUNT_BITS-1:0] tot_add;
  logic [OUT_W-1:0]      tot_clip;
  logic [IDX_W-1:0]      hi_r;
  logic [IDX_W-1:0]      lo_r;
  logic [COUNT_BITS-1:0] hi_c_r;
  logic [COUNT_BITS-1:0] lo_c_r;
  logic                  s_in_range;
  logic [EXT_W-1:0]      hi_val;
  logic [EXT_W-1:0]      lo_val;
  logic                  out_load;

  // output register
  logic                  out_vld_r;
  logic [OUT_W-1:0]      out_seen_r;
  logic [OUT_W-1:0]      out_tot_r;
  logic [MAXV_W-1:0]     out_hi_r;
  logic [MAXV_W-1:0]     out_lo_r;

  // pop only in normal running, and hold off behind a set end
  assign q_pop = (state_r == ST_RUN) && !q_stat.empty && !(b_vld_r && b_last_r);

  // update value with forwarding from the write of the previous edge
  assign b_cur    = (lw_vld_r && (lw_addr_r == b_idx_r)) ? lw_data_r : rd_data_r;
  assign b_inc    = (b_cur == COUNT_TOP) ? b_cur : b_cur + COUNT_BITS'(1);
  assign seen_inc = (seen_r == COUNT_TOP) ? seen_r : seen_r + COUNT_BITS'(1);

  // narrow the counts to the output width, saturating
  generate
    if (COUNT_BITS > OUT_W) begin : g_clip_wide
      assign seen_clip = (|seen_inc[COUNT_BITS-1:OUT_W]) ? '1 : seen_inc[OUT_W-1:0];
      assign tot_clip  = (|tot_r[COUNT_BITS-1:OUT_W]) ? '1 : tot_r[OUT_W-1:0];
    end else begin : g_clip_narrow
      assign seen_clip = OUT_W'(seen_inc);
      assign tot_clip  = OUT_W'(tot_r);
    end
  endgenerate

  // memory port selection
  always_comb begin
    rd_addr = IDX_W'(q_head.idx);
    wr_en   = 1'b0;
    wr_addr = b_idx_r;
    wr_data = b_inc;
    case (state_r)
      ST_CLEAR, ST_SCAN: begin
        rd_addr = sc_idx_r;
        wr_en   = 1'b1;
        wr_addr = sc_idx_r;
        wr_data = '0;
      end
      ST_RUN: begin
        wr_en = b_vld_r && b_hit_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // bin memory, read returns the value before a same-edge write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // last write tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_vld_r <= 1'b0;
    end else begin
      lw_vld_r <= wr_en;
    end
    lw_addr_r <= wr_addr;
    lw_data_r <= wr_data;
  end

  // sequencer
  assign out_load = (state_r == ST_HOLD) && !s_vld_r && (!out_vld_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sc_idx_r == IDX_END) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (b_vld_r && b_last_r) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sc_idx_r == IDX_END) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      sc_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_CLEAR) || (state_r == ST_SCAN)) begin
        sc_idx_r <= (sc_idx_r == IDX_END) ? '0 : sc_idx_r + IDX_W'(1);
      end
    end
  end

  // update stage registers and set counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      seen_r  <= '0;
    end else begin
      b_vld_r <= q_pop;
      if (b_vld_r) begin
        seen_r <= b_last_r ? '0 : seen_inc;
      end
    end
    if (q_pop) begin
      b_hit_r  <= q_head.hit;
      b_last_r <= q_head.last;
      b_idx_r  <= IDX_W'(q_head.idx);
      b_max_r  <= q_head.max_eff;
    end
    if (b_vld_r && b_last_r) begin
      seen_rep_r <= seen_clip;
      max_rep_r  <= b_max_r;
    end
  end

  // scan accumulation over the bins in range
  assign s_in_range = (CMP_W'(s_idx_r) < CMP_W'(max_rep_r));
  assign tot_sum    = {1'b0, tot_r} + {1'b0, rd_data_r};
  assign tot_add    = tot_sum[COUNT_BITS] ? COUNT_TOP : tot_sum[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= (state_r == ST_SCAN);
    end
    s_idx_r <= sc_idx_r;
    if (s_vld_r) begin
      if (s_idx_r == '0) begin
        tot_r  <= rd_data_r;
        hi_r   <= '0;
        lo_r   <= '0;
        hi_c_r <= rd_data_r;
        lo_c_r <= rd_data_r;
      end else if (s_in_range) begin
        tot_r <= tot_add;
        if (rd_data_r > hi_c_r) begin
          hi_r   <= s_idx_r;
          hi_c_r <= rd_data_r;
        end
        if (rd_data_r < lo_c_r) begin
          lo_r   <= s_idx_r;
          lo_c_r <= rd_data_r;
        end
      end
    end
  end

  // report values are bin index plus one
  assign hi_val = EXT_W'(hi_r) + EXT_W'(1);
  assign lo_val = EXT_W'(lo_r) + EXT_W'(1);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_r <= 1'b0;
    end
    if (out_load) begin
      out_seen_r <= seen_rep_r;
      out_tot_r  <= tot_clip;
      out_hi_r   <= hi_val[MAXV_W-1:0];
      out_lo_r   <= lo_val[MAXV_W-1:0];
    end
  end

  assign out_valid          = out_vld_r;
  assign out_numbers_seen   = out_seen_r;
  assign out_in_range_total = out_tot_r;
  assign out_most_frequent  = out_hi_r;
  assign out_least_frequent = out_lo_r;

endmodule

### rtl/histogram_tally_extremes_top.sv
// Histogram with most and least frequent value.
// Input channel: in_value (signed) and in_last, moved by in_valid / in_stall.
// A transaction with in_last high closes a data set and produces exactly one
// result transaction on out_valid / out_stall: numbers seen, in-range total,
// most and least frequent value; the other transactions produce nothing.
// cfg_wr_en / cfg_wr_data write max_value (bins 1 to max_value); the user must
// write it only when idle, which the block does not enforce. Throughput: one
// input transaction per cycle within a set while the queue has room. The bin
// memory is a read-modify-write with forwarding; a 4-entry queue parts the
// accepting side from the bin update, so input keeps flowing while the back
// is busy. Set end: the back sweeps every bin once (read, tally, clear); the
// next set's transactions queue up meanwhile and stall once the queue fills.
// Reset: a clearing pass zeroes the bin memory; transactions are queued but
// not counted until it finishes; max_value returns to 256.
// Receiver stall: the result holds in the output register; the next set may
// be counted meanwhile, and its report waits until the register is free.
module histogram_tally_extremes_top
  import hte_pkg::*;
#(
  parameter int BINS       = BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [MAXV_W-1:0]         cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_W-1:0]          out_numbers_seen,
  output logic [OUT_W-1:0]          out_in_range_total,
  output logic [MAXV_W-1:0]         out_most_frequent,
  output logic [MAXV_W-1:0]         out_least_frequent
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  item_t   q_item;
  item_t   q_head;

  // accept and classify
  hte_front #(
    .BINS (BINS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .in_last     (in_last),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  // decoupling queue
  hte_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // bin update, scan and report
  hte_back #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_head             (q_head),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_numbers_seen   (out_numbers_seen),
    .out_in_range_total (out_in_range_total),
    .out_most_frequent  (out_most_frequent),
    .out_least_frequent (out_least_frequent)
  );

  // the back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // reported values are never zero
  a_report_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_most_frequent != '0) && (out_least_frequent != '0))
    else $error("report value of zero");

  // a queued transaction pushed into an empty queue is not lost
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_stat.empty) |=> !q_stat.empty)
    else $error("push into empty queue lost");

endmodule
